// File: hw/rtl/gsdf_pkg.sv
// gsdf_pkg: shared types, sizes and grid symmetry functions for the
// grid symmetry dedup filter. No dependencies.
`default_nettype none

package gsdf_pkg;

    localparam int GRID_SIDE     = 3;
    localparam int CELL_BITS     = 2;
    localparam int TABLE_DEPTH   = 1024;

    localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int GRID_BITS     = GRID_CELLS * CELL_BITS;
    localparam int IN_GRID_W     = 18;
    localparam int ENTRY_COUNT_W = 11;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_VARIANTS  = 8;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef logic [GRID_BITS-1:0] grid_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef struct packed {
        logic                 kind;
        logic [IN_GRID_W-1:0] grid_cells;
    } in_t;

    typedef struct packed {
        logic                     is_new;
        logic                     was_stored;
        logic                     table_full;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic load;
        logic issue_read;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more;
        logic pending;
        logic out_free;
    } dp_stat_t;

    function automatic grid_t flip_diag(input grid_t g);
        grid_t o;
        o = '0;
        for (int r = 0; r < GRID_SIDE; r++)
            for (int c = 0; c < GRID_SIDE; c++)
                o[(r*GRID_SIDE + c)*CELL_BITS +: CELL_BITS] =
                    g[(c*GRID_SIDE + r)*CELL_BITS +: CELL_BITS];
        return o;
    endfunction

    function automatic grid_t flip_horiz(input grid_t g);
        grid_t o;
        o = '0;
        for (int r = 0; r < GRID_SIDE; r++)
            for (int c = 0; c < GRID_SIDE; c++)
                o[(r*GRID_SIDE + c)*CELL_BITS +: CELL_BITS] =
                    g[(r*GRID_SIDE + GRID_SIDE - 1 - c)*CELL_BITS +: CELL_BITS];
        return o;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gsdf_ram.sv
// gsdf_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module gsdf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gsdf_datapath.sv
// gsdf_datapath: variant registers, table RAM, scan index, compare and result register.
// Depends on gsdf_pkg and gsdf_ram.
`default_nettype none

module gsdf_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gsdf_pkg::in_t        grid,
    input  wire gsdf_pkg::ctrl_cmd_t  cmd,
    output gsdf_pkg::dp_stat_t        stat,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output gsdf_pkg::out_t            result
);

    gsdf_pkg::grid_t  var_reg  [gsdf_pkg::NUM_VARIANTS];
    gsdf_pkg::grid_t  var_next [gsdf_pkg::NUM_VARIANTS];
    logic             kind_reg;
    gsdf_pkg::count_t idx_reg, idx_next;
    gsdf_pkg::count_t count_reg, count_next;
    logic             seen_reg, seen_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    gsdf_pkg::out_t   out_reg, out_next;
    gsdf_pkg::grid_t  rdata;
    logic             hit;
    logic             has_room;
    logic             we;

    always_comb
    begin
        var_next[0] = grid.grid_cells[gsdf_pkg::GRID_BITS-1:0];
        for (int k = 1; k < gsdf_pkg::NUM_VARIANTS; k++)
        begin
            if (k % 2 == 1)
                var_next[k] = gsdf_pkg::flip_diag(var_next[k-1]);
            else
                var_next[k] = gsdf_pkg::flip_horiz(var_next[k-1]);
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < gsdf_pkg::NUM_VARIANTS; k++)
            if (rdata == var_reg[k])
                hit = 1'b1;
    end

    assign has_room = count_reg < gsdf_pkg::count_t'(gsdf_pkg::TABLE_DEPTH);
    assign we       = cmd.commit && (kind_reg == gsdf_pkg::KIND_SUBMIT) &&
                      !seen_reg && has_room;

    gsdf_ram #(
        .WIDTH(gsdf_pkg::GRID_BITS),
        .DEPTH(gsdf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(count_reg[gsdf_pkg::ADDR_W-1:0]),
        .wdata(var_reg[0]),
        .re   (cmd.issue_read),
        .raddr(idx_reg[gsdf_pkg::ADDR_W-1:0]),
        .rdata(rdata)
    );

    always_comb
    begin
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        pend_next      = cmd.issue_read;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (result_valid && result_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            idx_next  = '0;
            seen_next = 1'b0;
        end
        else
        begin
            if (cmd.issue_read)
                idx_next = idx_reg + gsdf_pkg::count_t'(1);
            if (pend_reg && hit)
                seen_next = 1'b1;
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (kind_reg == gsdf_pkg::KIND_CLEAR)
            begin
                count_next = '0;
            end
            else if (seen_reg)
            begin
                out_next.entry_count = gsdf_pkg::ENTRY_COUNT_W'(count_reg);
            end
            else if (has_room)
            begin
                count_next            = count_reg + gsdf_pkg::count_t'(1);
                out_next.is_new       = 1'b1;
                out_next.was_stored   = 1'b1;
                out_next.entry_count  = gsdf_pkg::ENTRY_COUNT_W'(count_next);
            end
            else
            begin
                out_next.is_new      = 1'b1;
                out_next.table_full  = 1'b1;
                out_next.entry_count = gsdf_pkg::ENTRY_COUNT_W'(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.load)
        begin
            kind_reg <= grid.kind;
            for (int k = 0; k < gsdf_pkg::NUM_VARIANTS; k++)
                var_reg[k] <= var_next[k];
        end
    end

    assign stat.more     = (idx_reg < count_reg) && !seen_reg;
    assign stat.pending  = pend_reg;
    assign stat.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gsdf_ctrl.sv
// gsdf_ctrl: state machine sequencing accept, table scan and result commit.
// Depends on gsdf_pkg.
`default_nettype none

module gsdf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                grid_valid,
    output logic                     grid_ready,
    input  wire logic                grid_kind,
    input  wire gsdf_pkg::dp_stat_t  stat,
    output gsdf_pkg::ctrl_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    assign grid_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.issue_read = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (grid_valid)
                begin
                    cmd.load = 1'b1;
                    if (grid_kind == gsdf_pkg::KIND_CLEAR)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue_read = stat.more;
                if (!stat.more && !stat.pending)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/grid_symmetry_dedup_filter.sv
// grid_symmetry_dedup_filter: top level joining controller and datapath.
// Depends on gsdf_pkg, gsdf_ctrl, gsdf_datapath (and gsdf_ram through it).
//
// Usage:
//   grid channel (grid_valid/grid_ready/grid): kind = clear empties the table,
//   otherwise grid_cells is checked against all stored grids under the eight
//   square symmetries and appended when new and there is room.
//   result channel (result_valid/result_ready/result): one result per item.
//   A submit with N stored grids scans the table with one table RAM read per
//   cycle, N up to 1024; a match ends the scan early. A clear skips the scan.
//   Throughput: one item at a time; grid_ready is high only when idle. The
//   scan length is set by the single read port of the table RAM.
//   A finished result sits in an output register, so the next item is taken
//   while it waits; if the receiver stalls, the following result waits in the
//   controller until the register frees.
//   Reset empties the table (count to zero) and drops any pending result.
`default_nettype none

module grid_symmetry_dedup_filter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            grid_valid,
    output logic                 grid_ready,
    input  wire gsdf_pkg::in_t   grid,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output gsdf_pkg::out_t       result
);

    gsdf_pkg::ctrl_cmd_t cmd;
    gsdf_pkg::dp_stat_t  stat;

    gsdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_valid(grid_valid),
        .grid_ready(grid_ready),
        .grid_kind (grid.kind),
        .stat      (stat),
        .cmd       (cmd)
    );

    gsdf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid        (grid),
        .cmd         (cmd),
        .stat        (stat),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

`default_nettype wire

// File: hw/rtl/gsdf_checker.sv
// gsdf_checker: port-level assertions for grid_symmetry_dedup_filter, bound to the top.
// Depends on gsdf_pkg.
`default_nettype none

module gsdf_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            grid_valid,
    input wire logic            grid_ready,
    input wire gsdf_pkg::in_t   grid,
    input wire logic            result_valid,
    input wire logic            result_ready,
    input wire gsdf_pkg::out_t  result
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        grid_valid && grid_ready |=> !grid_ready)
        else $error("grid_ready high right after a transfer");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_stored_is_new: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.was_stored |->
            result.is_new && !result.table_full && result.entry_count != '0)
        else $error("stored grid flags inconsistent");

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.table_full |-> result.is_new && !result.was_stored)
        else $error("table_full flags inconsistent");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        grid_valid && grid_ready && grid.kind == gsdf_pkg::KIND_CLEAR && !result_valid
            |=> ##1 result_valid && result.entry_count == '0 && !result.is_new)
        else $error("clear did not report an empty table");

endmodule

bind grid_symmetry_dedup_filter gsdf_checker u_gsdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_valid  (grid_valid),
    .grid_ready  (grid_ready),
    .grid        (grid),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

`default_nettype wire

// File: sim/tb_grid_symmetry_dedup_filter.sv
// Testbench for grid_symmetry_dedup_filter: random and directed grids checked
// against a scoreboard that tracks the table under the eight square symmetries.
// Depends on gsdf_pkg and the grid_symmetry_dedup_filter RTL only.
`timescale 1ns / 100ps

module tb_grid_symmetry_dedup_filter;

    localparam int SEND_IDLE[4] = '{0, 60, 0, 12};
    localparam int RECV_STALL[4] = '{0, 0, 60, 12};
    localparam int ITEMS_PER_PHASE = 141;
    localparam int SMALL_TABLE = 48;

    class dedup_scoreboard;
        gsdf_pkg::grid_t stored_grid[gsdf_pkg::TABLE_DEPTH];
        int              fill;
        gsdf_pkg::out_t  pending_verdicts[$];
        int              errors;
        int              checked;
        int              n_new;
        int              n_match;
        int              n_full;
        int              n_clear;
        int              peak_fill;

        function new();
            fill = 0;
            errors = 0;
            checked = 0;
            n_new = 0;
            n_match = 0;
            n_full = 0;
            n_clear = 0;
            peak_fill = 0;
        endfunction

        // s[0] mirrors rows, s[1] mirrors columns, s[2] transposes: all of D4
        static function gsdf_pkg::grid_t apply_sym(gsdf_pkg::grid_t g, int unsigned s);
            gsdf_pkg::grid_t o;
            int unsigned     sr;
            int unsigned     sc;
            int unsigned     tmp;
            o = '0;
            for (int r = 0; r < gsdf_pkg::GRID_SIDE; r++)
                for (int c = 0; c < gsdf_pkg::GRID_SIDE; c++)
                begin
                    sr = s[0] ? gsdf_pkg::GRID_SIDE - 1 - r : r;
                    sc = s[1] ? gsdf_pkg::GRID_SIDE - 1 - c : c;
                    if (s[2])
                    begin
                        tmp = sr;
                        sr = sc;
                        sc = tmp;
                    end
                    o[(r*gsdf_pkg::GRID_SIDE + c)*gsdf_pkg::CELL_BITS +: gsdf_pkg::CELL_BITS] =
                        g[(sr*gsdf_pkg::GRID_SIDE + sc)*gsdf_pkg::CELL_BITS +:
                          gsdf_pkg::CELL_BITS];
                end
            return o;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void note_grid(gsdf_pkg::in_t it);
            gsdf_pkg::out_t  e;
            gsdf_pkg::grid_t g;
            gsdf_pkg::grid_t v[gsdf_pkg::NUM_VARIANTS];
            bit              hit;
            e = '0;
            hit = 1'b0;
            if (it.kind == gsdf_pkg::KIND_CLEAR)
            begin
                fill = 0;
                n_clear++;
            end
            else
            begin
                g = it.grid_cells[gsdf_pkg::GRID_BITS-1:0];
                for (int s = 0; s < gsdf_pkg::NUM_VARIANTS; s++)
                    v[s] = apply_sym(g, s);
                for (int i = 0; i < fill && !hit; i++)
                    for (int s = 0; s < gsdf_pkg::NUM_VARIANTS; s++)
                        if (stored_grid[i] == v[s])
                            hit = 1'b1;
                if (hit)
                    n_match++;
                else if (fill < gsdf_pkg::TABLE_DEPTH)
                begin
                    stored_grid[fill] = g;
                    fill++;
                    e.is_new = 1'b1;
                    e.was_stored = 1'b1;
                    n_new++;
                end
                else
                begin
                    e.is_new = 1'b1;
                    e.table_full = 1'b1;
                    n_full++;
                end
            end
            if (fill > peak_fill)
                peak_fill = fill;
            e.entry_count = gsdf_pkg::ENTRY_COUNT_W'(fill);
            pending_verdicts.insert(pending_verdicts.size(), e);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(gsdf_pkg::out_t got);
            gsdf_pkg::out_t e;
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result transfer: is_new %0d was_stored %0d full %0d count %0d",
                       got.is_new, got.was_stored, got.table_full, got.entry_count);
                errors++;
                return;
            end
            e = pending_verdicts.pop_front();
            checked++;
            cmp("is_new", 32'(e.is_new), 32'(got.is_new));
            cmp("was_stored", 32'(e.was_stored), 32'(got.was_stored));
            cmp("table_full", 32'(e.table_full), 32'(got.table_full));
            cmp("entry_count", 32'(e.entry_count), 32'(got.entry_count));
        endfunction

        function void report_leftovers();
            if (pending_verdicts.size() != 0)
            begin
                $error("%0d expected results never arrived", pending_verdicts.size());
                errors += pending_verdicts.size();
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            grid_valid = 1'b0;
    logic            grid_ready;
    gsdf_pkg::in_t   grid = '0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    gsdf_pkg::out_t  result;

    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    dedup_scoreboard sb;

    grid_symmetry_dedup_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_valid   (grid_valid),
        .grid_ready   (grid_ready),
        .grid         (grid),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("grid_symmetry_dedup_filter: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic gsdf_pkg::in_t make_item(logic k,
                                                logic [gsdf_pkg::IN_GRID_W-1:0] cells);
        gsdf_pkg::in_t it;
        it.kind = k;
        it.grid_cells = cells;
        return it;
    endfunction

    task automatic push_grid(input gsdf_pkg::in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            grid_valid <= 1'b0;
            @(posedge clk);
        end
        grid_valid <= 1'b1;
        grid <= it;
        @(posedge clk);
        while (!grid_ready)
            @(posedge clk);
        sb.note_grid(it);
    endtask

    task automatic wait_table_settled();
        grid_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        gsdf_pkg::in_t   it;
        gsdf_pkg::grid_t g1;
        gsdf_pkg::grid_t recent[$];
        int              roll;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty clear, extremes, full symmetry orbit, clear and refill
        g1 = 18'h000E4;
        push_grid(make_item(gsdf_pkg::KIND_CLEAR, '1));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, '0));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, '0));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, '1));
        for (int s = 0; s < gsdf_pkg::NUM_VARIANTS; s++)
            push_grid(make_item(gsdf_pkg::KIND_SUBMIT, dedup_scoreboard::apply_sym(g1, s)));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, 18'h000E1));
        push_grid(make_item(gsdf_pkg::KIND_CLEAR, 18'h2AAAA));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, g1));
        push_grid(make_item(gsdf_pkg::KIND_SUBMIT, dedup_scoreboard::apply_sym(g1, 5)));
        wait_table_settled();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 4 || sb.fill >= SMALL_TABLE)
                    it = make_item(gsdf_pkg::KIND_CLEAR, gsdf_pkg::IN_GRID_W'($urandom()));
                else if (roll < 45 && recent.size() > 0)
                    it = make_item(gsdf_pkg::KIND_SUBMIT, dedup_scoreboard::apply_sym(
                        recent[$urandom_range(recent.size() - 1)], $urandom_range(7)));
                else if (roll < 60)
                    it = make_item(gsdf_pkg::KIND_SUBMIT,
                                   gsdf_pkg::IN_GRID_W'($urandom()) & 18'h15555);
                else
                    it = make_item(gsdf_pkg::KIND_SUBMIT, gsdf_pkg::IN_GRID_W'($urandom()));
                if (it.kind == gsdf_pkg::KIND_SUBMIT)
                begin
                    recent.insert(recent.size(), it.grid_cells);
                    if (recent.size() > 32)
                        void'(recent.pop_front());
                end
                push_grid(it);
            end
            wait_table_settled();
        end

        repeat (1100) @(posedge clk);
        sb.report_leftovers();
        $display("covered %0d submits: %0d new, %0d symmetric repeats, %0d dropped full",
                 sb.n_new + sb.n_match + sb.n_full, sb.n_new, sb.n_match, sb.n_full);
        $display("plus %0d clears; %0d results compared, peak table occupancy %0d",
                 sb.n_clear, sb.checked, sb.peak_fill);
        if (sb.errors == 0)
            $display("grid_symmetry_dedup_filter: match");
        else
            $display("grid_symmetry_dedup_filter: mismatch");
        $finish;
    end

endmodule
